### sv/tce_pkg.sv
package tce_pkg;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int ADDR_IN_W = 11;
    localparam int CURSOR_W  = 11;
    localparam int CELL_W    = 16;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    typedef logic [CELL_W-1:0] t_cell;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

    localparam int TAB_STEP = 8;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
    localparam t_cell             INIT_CELL  = 16'h0F00;

    localparam logic [PADDR_W-3:0] REG_TEXT_ATTR = 1'b0;

endpackage

### sv/tce_cmd_if.sv
interface tce_cmd_if;
    import tce_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [CHAR_W-1:0]    char_code;
    logic [ADDR_IN_W-1:0] cell_address;

    modport source (output valid, output opcode, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input opcode, input char_code, input cell_address,
                    output ready);
endinterface

### sv/tce_rsp_if.sv
interface tce_rsp_if;
    import tce_pkg::*;

    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   read_data;

    modport source (output valid, output cursor_position, output read_data, input ready);
    modport sink   (input valid, input cursor_position, input read_data, output ready);
endinterface

### sv/tce_cell_ram.sv
module tce_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  tce_pkg::t_cell    i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output tce_pkg::t_cell    o_rdata
);
    import tce_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tce_seq.sv
module tce_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tce_pkg::ATTR_W-1:0]    i_text_attr,
    tce_cmd_if.sink                       i_cmd,
    tce_rsp_if.source                     o_rsp
);
    import tce_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int AW1        = AW + 1;
    localparam int CW         = $clog2(COLUMNS);
    localparam int CTW        = CW + 1;
    localparam int RW         = $clog2(ROWS);
    localparam int COPY_N     = (ROWS - 2) * COLUMNS;
    localparam int SCR_N      = (ROWS - 1) * COLUMNS;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_BSWR, S_SCRPRE, S_SCROLL, S_CLEAR, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [AW-1:0]       r_base, n_base;
    logic [AW-1:0]       r_cnt, n_cnt;
    logic                r_rd_ok, n_rd_ok;
    logic                r_out_valid, n_out_valid;
    logic [CURSOR_W-1:0] r_out_cursor, n_out_cursor;
    t_cell               r_out_data, n_out_data;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_cell         wr_data, rd_data;
    logic [AW-1:0] cur_idx;
    logic [CTW-1:0] col_t;
    logic          moved, row_inc;
    t_cell         blank;

    assign cur_idx = r_base + AW'(r_col);
    assign blank   = {i_text_attr, {CHAR_W{1'b0}}};

    tce_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_rd_ok      = r_rd_ok;
        n_out_valid  = r_out_valid & ~o_rsp.ready;
        n_out_cursor = r_out_cursor;
        n_out_data   = r_out_data;
        wr_en        = 1'b0;
        wr_addr      = cur_idx;
        wr_data      = blank;
        rd_en        = 1'b0;
        rd_addr      = cur_idx;
        col_t        = '0;
        moved        = 1'b0;
        row_inc      = 1'b0;
        unique case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = INIT_CELL;
                if (r_cnt == AW'(CELL_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_rd_ok = 1'b0;
                    n_state = S_DONE;
                    unique case (i_cmd.opcode)
                        OP_PUT: begin
                            unique case (i_cmd.char_code)
                                CHAR_BS: begin
                                    if (r_col != '0) begin
                                        n_col   = r_col - 1'b1;
                                        rd_en   = 1'b1;
                                        rd_addr = cur_idx - 1'b1;
                                        n_state = S_BSWR;
                                    end
                                end
                                CHAR_CR: begin
                                    n_col = '0;
                                end
                                CHAR_LF: begin
                                    moved   = 1'b1;
                                    row_inc = 1'b1;
                                end
                                CHAR_TAB: begin
                                    col_t = {1'b0, r_col} + CTW'(TAB_STEP);
                                    moved = 1'b1;
                                end
                                default: begin
                                    wr_en   = 1'b1;
                                    wr_data = {i_text_attr, i_cmd.char_code};
                                    col_t   = {1'b0, r_col} + 1'b1;
                                    moved   = 1'b1;
                                end
                            endcase
                            if (moved) begin
                                if (col_t >= CTW'(COLUMNS)) begin
                                    n_col   = '0;
                                    row_inc = 1'b1;
                                end else begin
                                    n_col = col_t[CW-1:0];
                                end
                                if (row_inc) begin
                                    // bottom reached: row stays, screen scrolls up one
                                    if (r_row == RW'(ROWS - 2)) begin
                                        n_state = S_SCRPRE;
                                    end else begin
                                        n_row  = r_row + 1'b1;
                                        n_base = r_base + AW'(COLUMNS);
                                    end
                                end
                            end
                        end
                        OP_READ: begin
                            if (32'(i_cmd.cell_address) < 32'(CELL_COUNT)) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(i_cmd.cell_address);
                                n_rd_ok = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_base  = '0;
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BSWR: begin
                wr_en   = 1'b1;
                wr_data = {rd_data[CELL_W-1:CHAR_W], {CHAR_W{1'b0}}};
                n_state = S_DONE;
            end
            S_SCRPRE: begin
                rd_en   = 1'b1;
                rd_addr = AW'(COLUMNS);
                n_cnt   = '0;
                n_state = S_SCROLL;
            end
            S_SCROLL: begin
                // read one row ahead of the write pointer
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = (AW1'(r_cnt) < AW1'(COPY_N)) ? rd_data : blank;
                rd_en   = (AW1'(r_cnt) + 1'b1) < AW1'(COPY_N);
                rd_addr = AW'(AW1'(r_cnt) + AW1'(COLUMNS + 1));
                if (r_cnt == AW'(SCR_N - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                if (r_cnt == AW'(SCR_N - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = CURSOR_W'(cur_idx);
                    n_out_data   = r_rd_ok ? rd_data : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_base      <= n_base;
            r_cnt       <= n_cnt;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
        r_out_cursor <= n_out_cursor;
        r_out_data   <= n_out_data;
    end

    assign i_cmd.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.cursor_position = r_out_cursor;
    assign o_rsp.read_data       = r_out_data;

    a_row_above_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_row) < 32'(ROWS - 1)))
        else $error("cursor rests on bottom row");

    a_base_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) == 32'(r_row) * 32'(COLUMNS))
        else $error("row base out of step with cursor row");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(COLUMNS))
        else $error("cursor column beyond last column");

    a_idle_write_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_state == S_IDLE) |-> i_cmd.valid)
        else $error("cell write in idle without a command beat");

    a_scroll_read_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && rd_en) |-> (rd_addr > wr_addr))
        else $error("scroll read does not lead the write");

endmodule

### sv/text_console_char_engine_top.sv
// Print, CR, LF, tab, read and unknown opcodes go from accept straight to the result state;
// backspace reads the cell to its left, then clears its character; clear blanks the first
// (ROWS-1)*COLUMNS cells; a put that scrolls copies rows up over those cells after a scroll setup.
// One command is in work at a time over the single write port of the cell store; the next
// command is taken while a result waits, and a waiting result holds the following one.
// Reset (sync, active low): cursor home, attribute 0x0F, then every cell is filled with 0x0F00.
module text_console_char_engine_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tce_cmd_if.sink                        i_cmd,
    tce_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tce_pkg::PADDR_W-1:0]    paddr,
    input  logic [tce_pkg::PDATA_W-1:0]    pwdata,
    output logic [tce_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import tce_pkg::*;

    logic [ATTR_W-1:0] r_text_attr;
    logic              attr_sel;

    assign attr_sel = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= RESET_ATTR;
        end else if (psel && penable && pwrite && attr_sel) begin
            r_text_attr <= pwdata[ATTR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (attr_sel) begin
            prdata = PDATA_W'(r_text_attr);
        end
    end

    tce_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_attr (r_text_attr),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp)
    );

endmodule
